// ===== design/hrlp_pkg.sv =====
// shared types, codes and token tables for the http request line parser
// no dependencies; imported by the parser top level

package hrlp_pkg;

    // longest message in bytes; the message closes when this many bytes are counted
    localparam int MAX_MSG = 1024;

    // byte counter wide enough for MAX_MSG and never narrower than the length field
    localparam int CNT_W = ($clog2(MAX_MSG + 1) > 11) ? $clog2(MAX_MSG + 1) : 11;
    localparam int LEN_W = 11;

    // line phases
    localparam logic [2:0] PH_METHOD = 3'd0;
    localparam logic [2:0] PH_WS1    = 3'd1;
    localparam logic [2:0] PH_PATH   = 3'd2;
    localparam logic [2:0] PH_WS2    = 3'd3;
    localparam logic [2:0] PH_VER    = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    // byte classes seen by the line checker
    localparam logic [1:0] K_CHAR  = 2'd0;
    localparam logic [1:0] K_DELIM = 2'd1;
    localparam logic [1:0] K_EOL   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD      = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // token kinds
    localparam logic [1:0] TK_METHOD = 2'd0;
    localparam logic [1:0] TK_PATH   = 2'd1;
    localparam logic [1:0] TK_VER    = 2'd2;

    // terminator progress: none, cr, cr lf, cr lf cr, bare lf
    localparam logic [2:0] TP_NONE   = 3'd0;
    localparam logic [2:0] TP_CR     = 3'd1;
    localparam logic [2:0] TP_CRLF   = 3'd2;
    localparam logic [2:0] TP_CRLFCR = 3'd3;
    localparam logic [2:0] TP_LF     = 3'd4;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    // token strings, right justified: first char sits at the top of the used bytes
    localparam logic [87:0] TOK_TEXT [0:2][0:1] = '{
        '{88'("GET"), 88'("HEAD")},
        '{88'("/"), 88'("/index.html")},
        '{88'("HTTP/1.0"), 88'("HTTP/1.1")}
    };
    localparam logic [3:0] TOK_LEN [0:2][0:1] = '{
        '{4'd3, 4'd4},
        '{4'd1, 4'd11},
        '{4'd8, 4'd8}
    };

    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] pos;      // match position, saturates at 15
        logic [1:0] mask;     // set bit = candidate ruled out
        logic [1:0] status;
        logic       method;
        logic       version;
    } t_line;

    typedef struct packed {
        logic [1:0]       status;
        logic             method;
        logic             version;
        logic [LEN_W-1:0] len;
    } t_result;

    function automatic t_line token_char(t_line s, logic [1:0] t, logic [7:0] c);
        t_line      r;
        logic [3:0] idx;
        logic [7:0] ch;
        r = s;
        for (int k = 0; k < 2; k++) begin
            if (!s.mask[k]) begin
                if (s.pos >= TOK_LEN[t][k]) begin
                    r.mask[k] = 1'b1;
                end else begin
                    idx = TOK_LEN[t][k] - 4'd1 - s.pos;
                    ch  = TOK_TEXT[t][k][{idx, 3'b000} +: 8];
                    if (ch != c) begin
                        r.mask[k] = 1'b1;
                    end
                end
            end
        end
        if (s.pos != 4'hF) begin
            r.pos = s.pos + 4'd1;
        end
        return r;
    endfunction

    // {hit, index of the matching candidate}
    function automatic logic [1:0] token_match(t_line s, logic [1:0] t);
        logic [1:0] m;
        m = 2'b00;
        if (!s.mask[1] && s.pos == TOK_LEN[t][1]) begin
            m = 2'b11;
        end
        if (!s.mask[0] && s.pos == TOK_LEN[t][0]) begin
            m = 2'b10;
        end
        return m;
    endfunction

    function automatic t_line line_feed(t_line s, logic [1:0] kind, logic [7:0] c);
        t_line      r;
        logic [1:0] m;
        r = s;
        m = 2'b00;
        unique case (s.phase)
            PH_METHOD: begin
                if (kind == K_CHAR) begin
                    r = token_char(s, TK_METHOD, c);
                end else begin
                    m = token_match(s, TK_METHOD);
                    if (m[1]) begin
                        r.method = m[0];
                    end
                    if (m[1] && kind == K_DELIM) begin
                        r.phase = PH_WS1;
                    end else begin
                        r.status = ST_BAD;
                        r.phase  = PH_DONE;
                    end
                end
            end
            PH_WS1, PH_WS2: begin
                if (kind == K_EOL) begin
                    r.status = (s.phase == PH_WS1) ? ST_NOTFOUND : ST_BAD;
                    r.phase  = PH_DONE;
                end else if (kind == K_CHAR) begin
                    r.pos   = 4'd0;
                    r.mask  = 2'b00;
                    r.phase = s.phase + 3'd1;
                    r = token_char(r, (s.phase == PH_WS1) ? TK_PATH : TK_VER, c);
                end
            end
            PH_PATH: begin
                if (kind == K_CHAR) begin
                    r = token_char(s, TK_PATH, c);
                end else begin
                    m = token_match(s, TK_PATH);
                    if (!m[1]) begin
                        r.status = ST_NOTFOUND;
                        r.phase  = PH_DONE;
                    end else if (kind == K_EOL) begin
                        r.status = ST_BAD;
                        r.phase  = PH_DONE;
                    end else begin
                        r.phase = PH_WS2;
                    end
                end
            end
            PH_VER: begin
                if (kind == K_CHAR) begin
                    r = token_char(s, TK_VER, c);
                end else begin
                    m = token_match(s, TK_VER);
                    if (m[1]) begin
                        r.version = m[0];
                        r.status  = ST_OK;
                    end else begin
                        r.status = ST_BAD;
                    end
                    r.phase = PH_DONE;
                end
            end
            default: begin
                r = s;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== design/http_request_line_parser.sv =====
// http request line parser top level: byte intake, line checker state, result queue
// depends on hrlp_pkg for codes, token tables and the line checker functions

// The parser takes one request byte per cycle while o_in_stall is low and
// never needs more: every byte is classified and folded into the line
// checker state in the cycle it is transferred, by a few compares against
// the token tables. A message ends at the first CR LF CR LF or LF LF (also
// CR LF LF), or when MAX_MSG bytes have been counted; a zero byte closes
// the text and later bytes are only counted. The result (status, held
// method, held minor version, length) is registered into the result
// register, or into the one skid entry while that register holds a stalled
// result, so input keeps flowing while a result waits; o_in_stall goes high
// only when two results are backed up behind a stalled output. Method and
// version stay held across messages and change only when their token matches.

module http_request_line_parser
    import hrlp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // byte input channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_data_byte,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_status,
    output logic             o_method_code,
    output logic             o_version_minor,
    output logic [LEN_W-1:0] o_message_length
);

    // message state
    t_line            r_line,  n_line;
    logic [2:0]       r_term,  n_term;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic             r_ended, n_ended;

    // result queue: head register and one skid entry
    t_result r_head, n_head;
    t_result r_skid, n_skid;
    logic    r_head_vld, n_head_vld;
    logic    r_skid_vld, n_skid_vld;

    logic             accept;
    logic             take;
    logic             msg_end;
    logic [1:0]       kind;
    logic [CNT_W-1:0] cnt_inc;
    t_line            line_byte;
    t_line            line_fin;
    t_result          result;

    assign o_in_stall = r_skid_vld;
    assign accept     = i_in_valid && !r_skid_vld;
    assign take       = r_head_vld && !i_out_stall;

    // byte class
    always_comb begin
        if (i_data_byte == CH_NUL || i_data_byte == CH_CR || i_data_byte == CH_LF) begin
            kind = K_EOL;
        end else if (i_data_byte == CH_SP || i_data_byte == CH_TAB) begin
            kind = K_DELIM;
        end else begin
            kind = K_CHAR;
        end
    end

    // per-byte update of the line checker and the terminator tracker
    always_comb begin
        cnt_inc   = r_cnt + CNT_W'(1);
        line_byte = r_line;
        n_term    = r_term;
        n_ended   = r_ended;
        msg_end   = 1'b0;
        if (!r_ended) begin
            line_byte = line_feed(r_line, kind, i_data_byte);
            if (i_data_byte == CH_NUL) begin
                n_ended = 1'b1;
            end else if (i_data_byte == CH_LF) begin
                if (r_term == TP_CRLF || r_term == TP_CRLFCR || r_term == TP_LF) begin
                    msg_end = 1'b1;
                end else begin
                    n_term = (r_term == TP_CR) ? TP_CRLF : TP_LF;
                end
            end else if (i_data_byte == CH_CR) begin
                n_term = (r_term == TP_CRLF) ? TP_CRLFCR : TP_CR;
            end else begin
                n_term = TP_NONE;
            end
        end
        if (cnt_inc >= CNT_W'(MAX_MSG)) begin
            msg_end = 1'b1;
        end

        // an unfinished first line is closed as if its line ended here
        if (line_byte.phase != PH_DONE) begin
            line_fin = line_feed(line_byte, K_EOL, CH_NUL);
        end else begin
            line_fin = line_byte;
        end

        result.status  = line_fin.status;
        result.method  = line_fin.method;
        result.version = line_fin.version;
        result.len     = cnt_inc[LEN_W-1:0];

        n_line = line_byte;
        n_cnt  = cnt_inc;
        if (msg_end) begin
            // back to the start of a message, held fields kept
            n_line.phase   = PH_METHOD;
            n_line.pos     = 4'd0;
            n_line.mask    = 2'b00;
            n_line.status  = ST_OK;
            n_line.method  = line_fin.method;
            n_line.version = line_fin.version;
            n_term         = TP_NONE;
            n_cnt          = '0;
            n_ended        = 1'b0;
        end
    end

    // result queue
    always_comb begin
        n_head     = r_head;
        n_skid     = r_skid;
        n_head_vld = r_head_vld;
        n_skid_vld = r_skid_vld;
        if (r_head_vld && !take) begin
            if (accept && msg_end) begin
                n_skid     = result;
                n_skid_vld = 1'b1;
            end
        end else if (r_skid_vld) begin
            n_head     = r_skid;
            n_head_vld = 1'b1;
            n_skid_vld = 1'b0;
        end else if (accept && msg_end) begin
            n_head     = result;
            n_head_vld = 1'b1;
        end else begin
            n_head_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line.phase   <= PH_METHOD;
            r_line.pos     <= 4'd0;
            r_line.mask    <= 2'b00;
            r_line.status  <= ST_OK;
            r_line.method  <= 1'b0;
            r_line.version <= 1'b0;
            r_term         <= TP_NONE;
            r_cnt          <= '0;
            r_ended        <= 1'b0;
            r_head_vld     <= 1'b0;
            r_skid_vld     <= 1'b0;
        end else begin
            if (accept) begin
                r_line  <= n_line;
                r_term  <= n_term;
                r_cnt   <= n_cnt;
                r_ended <= n_ended;
            end
            r_head_vld <= n_head_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_out_valid      = r_head_vld;
    assign o_status         = r_head.status;
    assign o_method_code    = r_head.method;
    assign o_version_minor  = r_head.version;
    assign o_message_length = r_head.len;

endmodule

// ===== design/hrlp_checker.sv =====
// port-level checks for the http request line parser, bound to the top level
// depends on hrlp_pkg for the status codes and the length width

module hrlp_checker
    import hrlp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [1:0]       o_status,
    input logic             o_method_code,
    input logic             o_version_minor,
    input logic [LEN_W-1:0] o_message_length
);

    // input only backs up when a result is already waiting
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    // skid fills only behind a stalled result
    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stall rose without a stalled result");

    // a stalled result stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_method_code) && $stable(o_version_minor)
            && $stable(o_message_length))
        else $error("stalled result changed");

    // only the three defined status codes appear
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_BAD
            || o_status == ST_NOTFOUND))
        else $error("undefined status code");

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_status         (o_status),
    .o_method_code    (o_method_code),
    .o_version_minor  (o_version_minor),
    .o_message_length (o_message_length)
);

// ===== tb/request_line_checker.sv =====
// result checker for the http request line parser: predicts each result from the byte stream
// depends on hrlp_pkg for codes and the result layout; instantiated beside the parser by testbench

module request_line_checker
    import hrlp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [7:0]       i_data_byte,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [1:0]       i_status,
    input  logic             i_method_code,
    input  logic             i_version_minor,
    input  logic [LEN_W-1:0] i_message_length,
    output int               o_mismatches,
    output int               o_awaited
);

    // predicted parser state
    logic [2:0]  line_step;
    logic [3:0]  token_pos;
    logic [1:0]  ruled_out;     // set bit = candidate word no longer possible
    logic [1:0]  verdict_code;
    logic        method_held;
    logic        version_held;
    logic [2:0]  eol_run;
    int unsigned bytes_in_msg;
    logic        text_closed;

    t_result     awaited_results[$];
    t_result     want;
    int          mismatch_total = 0;

    initial begin
        o_mismatches = 0;
        o_awaited    = 0;
    end

    function automatic string token_word(input logic [1:0] t, input int k);
        if (t == TK_METHOD) begin
            if (k != 0) return "HEAD";
            return "GET";
        end else if (t == TK_PATH) begin
            if (k != 0) return "/index.html";
            return "/";
        end
        if (k != 0) return "HTTP/1.1";
        return "HTTP/1.0";
    endfunction

    task automatic match_letter(input logic [1:0] t, input logic [7:0] c);
        string w;
        for (int k = 0; k < 2; k++) begin
            w = token_word(t, k);
            if (!ruled_out[k] && (token_pos >= w.len() || w[token_pos] != c)) begin
                ruled_out[k] = 1'b1;
            end
        end
        if (token_pos != 4'hF) begin
            token_pos = token_pos + 4'd1;
        end
    endtask

    // lower candidate wins when both would fit
    function automatic int token_hit(input logic [1:0] t);
        string w;
        int    found;
        found = -1;
        for (int k = 1; k >= 0; k--) begin
            w = token_word(t, k);
            if (!ruled_out[k] && token_pos == w.len()) begin
                found = k;
            end
        end
        return found;
    endfunction

    task automatic settle(input logic [1:0] code);
        verdict_code = code;
        line_step    = PH_DONE;
    endtask

    task automatic advance_line(input logic [1:0] kind, input logic [7:0] c);
        int hit;
        hit = -1;
        case (line_step)
            PH_METHOD: begin
                if (kind == K_CHAR) begin
                    match_letter(TK_METHOD, c);
                end else begin
                    hit = token_hit(TK_METHOD);
                    if (hit >= 0) begin
                        method_held = (hit != 0);
                    end
                    if (hit >= 0 && kind == K_DELIM) begin
                        line_step = PH_WS1;
                    end else begin
                        settle(ST_BAD);
                    end
                end
            end
            PH_WS1, PH_WS2: begin
                if (kind == K_EOL) begin
                    settle((line_step == PH_WS1) ? ST_NOTFOUND : ST_BAD);
                end else if (kind == K_CHAR) begin
                    token_pos = 4'd0;
                    ruled_out = 2'b00;
                    line_step = line_step + 3'd1;
                    match_letter((line_step == PH_PATH) ? TK_PATH : TK_VER, c);
                end
            end
            PH_PATH: begin
                if (kind == K_CHAR) begin
                    match_letter(TK_PATH, c);
                end else begin
                    hit = token_hit(TK_PATH);
                    if (hit < 0) begin
                        settle(ST_NOTFOUND);
                    end else if (kind == K_EOL) begin
                        settle(ST_BAD);
                    end else begin
                        line_step = PH_WS2;
                    end
                end
            end
            PH_VER: begin
                if (kind == K_CHAR) begin
                    match_letter(TK_VER, c);
                end else begin
                    hit = token_hit(TK_VER);
                    if (hit >= 0) begin
                        version_held = (hit != 0);
                        settle(ST_OK);
                    end else begin
                        settle(ST_BAD);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic clear_message();
        line_step    = PH_METHOD;
        token_pos    = 4'd0;
        ruled_out    = 2'b00;
        verdict_code = ST_OK;
        eol_run      = TP_NONE;
        bytes_in_msg = 0;
        text_closed  = 1'b0;
    endtask

    task automatic take_byte(input logic [7:0] b);
        logic    closes;
        t_result r;
        closes = 1'b0;
        bytes_in_msg++;
        if (!text_closed) begin
            if (b == CH_NUL) begin
                text_closed = 1'b1;
                advance_line(K_EOL, b);
            end else begin
                if (b == CH_CR || b == CH_LF) begin
                    advance_line(K_EOL, b);
                end else if (b == CH_SP || b == CH_TAB) begin
                    advance_line(K_DELIM, b);
                end else begin
                    advance_line(K_CHAR, b);
                end
                // blank line after cr lf or after a bare lf closes the message
                if (b == CH_LF) begin
                    if (eol_run != TP_NONE && eol_run != TP_CR) begin
                        closes = 1'b1;
                    end else begin
                        eol_run = (eol_run == TP_CR) ? TP_CRLF : TP_LF;
                    end
                end else if (b == CH_CR) begin
                    eol_run = (eol_run == TP_CRLF) ? TP_CRLFCR : TP_CR;
                end else begin
                    eol_run = TP_NONE;
                end
            end
        end
        if (bytes_in_msg >= MAX_MSG) begin
            closes = 1'b1;
        end
        if (closes) begin
            if (line_step != PH_DONE) begin
                advance_line(K_EOL, CH_NUL);
            end
            r.status  = verdict_code;
            r.method  = method_held;
            r.version = version_held;
            r.len     = bytes_in_msg[LEN_W-1:0];
            awaited_results.push_back(r);
            clear_message();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_message();
            method_held  = 1'b0;
            version_held = 1'b0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    if (mismatch_total < 10) begin
                        $display("[%0t] result with nothing pending: status %0d method %0d",
                                 $time, i_status, i_method_code,
                                 " version %0d length %0d", i_version_minor,
                                 i_message_length);
                    end
                    mismatch_total++;
                end else begin
                    want = awaited_results.pop_front();
                    if (want.status != i_status || want.method != i_method_code ||
                        want.version != i_version_minor || want.len != i_message_length) begin
                        if (mismatch_total < 10) begin
                            $display("[%0t] mismatch: expected status %0d method %0d",
                                     $time, want.status, want.method,
                                     " version %0d length %0d", want.version, want.len);
                            $display("           actual   status %0d method %0d",
                                     i_status, i_method_code,
                                     " version %0d length %0d", i_version_minor,
                                     i_message_length);
                        end
                        mismatch_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                take_byte(i_data_byte);
            end
        end
        o_mismatches = mismatch_total;
        o_awaited    = awaited_results.size();
    end

endmodule

// ===== tb/testbench.sv =====
// top of the http request line parser testbench: clock, reset, request stimulus, result stalls
// depends on hrlp_pkg, http_request_line_parser and request_line_checker

module testbench;
    import hrlp_pkg::*;

    // no transfer on either channel for this long means the run is stuck
    localparam int QUIET_LIMIT      = 4000;
    // long output hold-off, in cycles, so two results back up and the byte side stalls
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int RANDOM_BYTE_GOAL = 600;
    localparam int REQUEST_GOAL     = 24;

    typedef enum int {KEEP, CLIP, SWAP, EXTEND, DROP} t_mangle;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic [7:0]       i_data_byte = 8'h00;
    logic             i_out_stall = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [1:0]       o_status;
    logic             o_method_code;
    logic             o_version_minor;
    logic [LEN_W-1:0] o_message_length;

    int fail_total;
    int pending_total;

    // stimulus bookkeeping
    logic [7:0] request_bytes[$];
    int         bytes_sent      = 0;
    int         requests_sent   = 0;
    bit         no_gaps         = 1'b0;  // send the current request back to back
    int         eol_mix         = 0;     // 0 cr lf, 1 bare lf, 2 either per line
    bit         hold_off_wanted = 1'b0;
    bit         hold_off_done   = 1'b0;
    int         quiet_cycles    = 0;

    always #1 i_clk = ~i_clk;

    http_request_line_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_method_code    (o_method_code),
        .o_version_minor  (o_version_minor),
        .o_message_length (o_message_length)
    );

    request_line_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_status         (o_status),
        .i_method_code    (o_method_code),
        .i_version_minor  (o_version_minor),
        .i_message_length (o_message_length),
        .o_mismatches     (fail_total),
        .o_awaited        (pending_total)
    );

    // watchdog: any transfer on either side restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // one byte transfer, with an optional idle gap in front of it
    task automatic send_byte(input logic [7:0] b);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        gap  = 0;
        if (!no_gaps) begin
            if (pick >= 93) begin
                gap = $urandom_range(6, 25);
            end else if (pick >= 65) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        // payload holds while the parser stalls
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_request();
        foreach (request_bytes[i]) begin
            send_byte(request_bytes[i]);
        end
        request_bytes.delete();
        requests_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            request_bytes.push_back(s[i]);
        end
    endtask

    task automatic add_eol();
        bit bare;
        bare = (eol_mix == 1) || (eol_mix == 2 && $urandom_range(0, 1) == 1);
        if (!bare) begin
            request_bytes.push_back(CH_CR);
        end
        request_bytes.push_back(CH_LF);
    endtask

    task automatic add_blanks();
        repeat ($urandom_range(1, 3)) begin
            request_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
        end
    endtask

    function automatic logic [7:0] token_noise();
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    // header or trailing text: printable mostly, some high bytes and blanks
    task automatic add_junk(input int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                request_bytes.push_back(token_noise());
            end else if (pick < 9) begin
                request_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
            end else begin
                request_bytes.push_back(CH_SP);
            end
        end
    endtask

    // a token that is right most of the time, else clipped, altered, extended or dropped
    task automatic add_token(input string word);
        t_mangle how;
        int      spot;
        how  = ($urandom_range(0, 99) < 80) ? KEEP : t_mangle'($urandom_range(1, 4));
        spot = $urandom_range(0, word.len() - 1);
        if (how != DROP) begin
            for (int i = 0; i < word.len(); i++) begin
                if (how == SWAP && i == spot) begin
                    request_bytes.push_back(token_noise());
                end else if (!(how == CLIP && i == word.len() - 1)) begin
                    request_bytes.push_back(word[i]);
                end
            end
            if (how == EXTEND) begin
                request_bytes.push_back(token_noise());
            end
        end
    endtask

    // fill up to the message size limit; any_byte also lets zeros and line ends in
    task automatic pad_to_limit(input bit any_byte);
        while (request_bytes.size() < MAX_MSG) begin
            request_bytes.push_back(any_byte ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(8'h20, 8'hFF)));
        end
    endtask

    // mostly well formed request with random content; cut selects an early line end
    task automatic build_request();
        int cut;
        cut = ($urandom_range(0, 99) < 12) ? $urandom_range(1, 4) : 0;
        if ($urandom_range(0, 19) == 0) begin
            add_blanks();
        end
        if ($urandom_range(0, 1)) add_token("HEAD");
        else add_token("GET");
        if (cut != 1) begin
            add_blanks();
            if (cut != 2) begin
                if ($urandom_range(0, 1)) add_token("/index.html");
                else add_token("/");
                if (cut != 3) begin
                    add_blanks();
                    if (cut != 4) begin
                        if ($urandom_range(0, 1)) add_token("HTTP/1.1");
                        else add_token("HTTP/1.0");
                        if ($urandom_range(0, 4) == 0) begin
                            add_blanks();
                            add_junk($urandom_range(1, 10));
                        end
                    end
                end
            end
        end
        add_eol();
        repeat ($urandom_range(0, 2)) begin
            add_text("X-");
            add_junk($urandom_range(1, 12));
            add_eol();
        end
        add_eol();
    endtask

    // result side: random stall pattern, plus one long hold-off on request
    initial begin
        int pick;
        int span;
        @(posedge i_clk);
        forever begin
            if (hold_off_wanted && !hold_off_done) begin
                hold_off_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    i_out_stall <= 1'b0;
                    span = $urandom_range(1, 8);
                end else if (pick < 80) begin
                    i_out_stall <= 1'b1;
                    span = $urandom_range(1, 3);
                end else if (pick < 90) begin
                    i_out_stall <= 1'b1;
                    span = $urandom_range(8, 30);
                end else begin
                    // stretch with no stall at all
                    i_out_stall <= 1'b0;
                    span = $urandom_range(30, 80);
                end
                repeat (span) @(posedge i_clk);
            end
        end
    end

    // byte side: reset, directed requests, then random requests
    initial begin
        int random_start;
        int random_requests;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // plain requests, both methods, both versions, both line end styles
        eol_mix = 0;
        add_text("GET / HTTP/1.0"); add_eol(); add_eol(); send_request();
        eol_mix = 1;
        add_text("HEAD /index.html HTTP/1.1"); add_eol(); add_eol(); send_request();
        // empty method
        add_text(" GET / HTTP/1.1"); add_eol(); add_eol(); send_request();
        // line ends right after the method, which is still held
        eol_mix = 0;
        add_text("HEAD"); add_eol(); add_eol(); send_request();
        // empty path after method and blank
        eol_mix = 1;
        add_text("GET "); add_eol(); add_eol(); send_request();
        // line ends right after a good path
        add_text("GET /index.html"); add_eol(); add_eol(); send_request();
        // empty version after path and tab
        add_text("GET /"); request_bytes.push_back(CH_TAB); add_eol(); add_eol();
        send_request();
        // text after the version is ignored, header line in between
        eol_mix = 0;
        add_text("GET"); request_bytes.push_back(CH_TAB); add_text("/ HTTP/1.1 extra");
        add_eol(); add_text("Host: a"); add_eol(); add_eol(); send_request();
        // unknown path, unknown method, unknown version
        eol_mix = 1;
        add_text("GET /x HTTP/1.1"); add_eol(); add_eol(); send_request();
        add_text("POST / HTTP/1.1"); add_eol(); add_eol(); send_request();
        add_text("GET / HTTP/1.2"); add_eol(); add_eol(); send_request();
        // cr lf followed by a bare lf also closes
        eol_mix = 0;
        add_text("HEAD / HTTP/1.0"); add_eol(); request_bytes.push_back(CH_LF);
        send_request();
        // top byte value inside the path
        add_text("GET /"); request_bytes.push_back(8'hFF); add_text(" HTTP/1.0");
        add_eol(); add_eol(); send_request();
        // zero byte inside the first line: the rest only counts up to the size limit
        add_text("GET /ind"); request_bytes.push_back(CH_NUL); pad_to_limit(1'b1);
        send_request();
        // size limit reached inside the first line
        add_text("HEAD "); pad_to_limit(1'b0); send_request();

        random_start    = bytes_sent;
        random_requests = 0;
        while (bytes_sent - random_start < RANDOM_BYTE_GOAL || random_requests < REQUEST_GOAL) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            eol_mix = $urandom_range(0, 2);
            if (random_requests >= 20 && !hold_off_wanted) begin
                // short requests back to back while the result side holds off
                hold_off_wanted = 1'b1;
                no_gaps         = 1'b1;
                eol_mix         = 1;
                repeat (12) begin
                    add_text("GET / HTTP/1.0"); add_eol(); add_eol(); send_request();
                end
                random_requests += 12;
            end else if ($urandom_range(0, 99) < 15) begin
                // noise, closed by a blank line in case it did not close itself
                repeat ($urandom_range(1, 40)) begin
                    request_bytes.push_back(8'($urandom_range(1, 255)));
                end
                add_eol(); add_eol();
                send_request();
                random_requests++;
            end else begin
                build_request();
                send_request();
                random_requests++;
            end
        end
        i_in_valid <= 1'b0;

        // let the last prediction land, then drain the results
        @(posedge i_clk);
        while (pending_total != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_total == 0 && pending_total == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
